[sv/html_entity_decoder_macros.svh]
// Assertion macros for the entity decoder checker
`ifndef HTML_ENTITY_DECODER_MACROS_SVH
`define HTML_ENTITY_DECODER_MACROS_SVH

// implication checked on every clock edge outside reset
`define HED_ASSERT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define HED_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[sv/hed_pkg.sv]
`timescale 1ns / 1ps
package hed_pkg;
  localparam int unsigned Window  = 12;
  localparam int unsigned HoldMax = Window - 1;
  localparam int unsigned HcW     = $clog2(HoldMax + 1);
  localparam int unsigned HiW     = $clog2(HoldMax);
  localparam int unsigned OutMax  = Window + 1;
  localparam int unsigned OcW     = $clog2(OutMax + 1);

  localparam logic [7:0] ChAmp  = 8'h26;
  localparam logic [7:0] ChSemi = 8'h3B;
  localparam logic [7:0] ChVt   = 8'h0B;

  typedef enum logic [2:0] {
    ST_IDLE,     // waiting for an input byte
    ST_PARSE,    // walking held bytes for a numeric value
    ST_NAME,     // matching entity names
    ST_EMIT      // sending the result bytes
  } state_t;

  typedef enum logic [1:0] {
    PH_WS, PH_SIGN, PH_PFX, PH_DIG
  } phase_t;

  // controller -> datapath
  typedef struct packed {
    logic       take;       // latch the input byte and do its immediate work
    logic       parse_step; // one number parser step over the held bytes
    logic       parse_init;
    logic       name_step;  // one entity compared
    logic       finish;     // build the output list from decode result
    logic       emit_pop;   // one result byte taken
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic need_decode;  // ';' closing a window with a body
    logic numeric;
    logic parse_done;
    logic name_done;
    logic emit_any;     // output list not empty
    logic emit_last;    // one byte left
  } stat_t;

  typedef struct packed {
    logic [7:0][7:0] name;
    logic [2:0]      len;
    logic [7:0]      text0;
    logic [7:0]      text1;
    logic            two;
  } entity_t;

  function automatic entity_t ent(input logic [3:0] k);
    entity_t e;
    e = '0;
    case (k)
      4'd0:  begin e.name = {40'h0, "pma"}; e.len = 3'd3; e.text0 = "&"; end
      4'd1:  begin e.name = {48'h0, "tl"}; e.len = 3'd2; e.text0 = "<"; end
      4'd2:  begin e.name = {48'h0, "tg"}; e.len = 3'd2; e.text0 = ">"; end
      4'd3:  begin e.name = {32'h0, "touq"}; e.len = 3'd4; e.text0 = 8'h22; end
      4'd4:  begin e.name = {32'h0, "sopa"}; e.len = 3'd4; e.text0 = 8'h27; end
      4'd5:  begin
        e.name = {32'h0, "psbn"}; e.len = 3'd4; e.text0 = 8'hC2; e.text1 = 8'hA0;
        e.two = 1'b1;
      end
      4'd6:  begin e.name = {40'h0, "los"}; e.len = 3'd3; e.text0 = "/"; end
      4'd7:  begin e.name = {24'h0, "noloc"}; e.len = 3'd5; e.text0 = ":"; end
      4'd8:  begin e.name = {16'h0, "slauqe"}; e.len = 3'd6; e.text0 = "="; end
      4'd9:  begin e.name = {24'h0, "tseuq"}; e.len = 3'd5; e.text0 = "?"; end
      4'd10: begin e.name = {40'h0, "mun"}; e.len = 3'd3; e.text0 = "#"; end
      4'd11: begin e.name = {32'h0, "rapl"}; e.len = 3'd4; e.text0 = "("; end
      4'd12: begin e.name = {32'h0, "rapr"}; e.len = 3'd4; e.text0 = ")"; end
      4'd13: begin e.name = {24'h0, "ammoc"}; e.len = 3'd5; e.text0 = ","; end
      4'd14: begin e.name = {32'h0, "imes"}; e.len = 3'd4; e.text0 = ";"; end
      default: begin e.name = {16'h0, "doirep"}; e.len = 3'd6; e.text0 = "."; end
    endcase
    return e;
  endfunction

  function automatic logic [4:0] digit_val(input logic [7:0] c, input logic hex);
    logic [4:0] v;
    v = 5'h10;
    if (c >= "0" && c <= "9") v = {1'b0, c[3:0]};
    else if (hex && ((c >= "a" && c <= "f") || (c >= "A" && c <= "F")))
      v = {1'b0, 4'(c[3:0] + 4'd9)};
    return v;
  endfunction

  function automatic logic [7:0] fold(input logic [7:0] c);
    return (c >= "A" && c <= "Z") ? (c | 8'h20) : c;
  endfunction
endpackage

[sv/hed_ctrl.sv]
`timescale 1ns / 1ps
module hed_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  output hed_pkg::cmd_t  cmd,
  input  hed_pkg::stat_t st
);
  import hed_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  // byte taken in IDLE decides next state from status after the take
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (st.need_decode) state_nxt = st.numeric ? ST_PARSE : ST_NAME;
          else if (st.emit_any) state_nxt = ST_EMIT;
        end
      end
      // a code point above range decodes to nothing: straight back to IDLE
      ST_PARSE: if (st.parse_done) state_nxt = st.emit_any ? ST_EMIT : ST_IDLE;
      ST_NAME:  if (st.name_done) state_nxt = st.emit_any ? ST_EMIT : ST_IDLE;
      ST_EMIT: begin
        if (!out_stall && st.emit_last) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_stall = 1'b1;
    out_valid = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.take = in_valid;
        cmd.parse_init = in_valid;
      end
      ST_PARSE: begin
        cmd.parse_step = 1'b1;
        cmd.finish = st.parse_done;
      end
      ST_NAME: begin
        cmd.name_step = 1'b1;
        cmd.finish = st.name_done;
      end
      ST_EMIT: begin
        out_valid = 1'b1;
        cmd.emit_pop = !out_stall;
      end
      default: ;
    endcase
  end
endmodule

[sv/hed_dp.sv]
`timescale 1ns / 1ps
module hed_dp (
  input  logic           clk,
  input  logic           rst_n,
  input  logic [7:0]     in_byte,
  input  logic           in_end,
  output logic [7:0]     out_byte,
  output logic           out_run_last,
  input  hed_pkg::cmd_t  cmd,
  output hed_pkg::stat_t st
);
  import hed_pkg::*;

  logic             inref_r, inref_nxt;
  logic [HcW-1:0]   hcnt_r, hcnt_nxt;
  logic [7:0]       held_r [HoldMax];
  logic [7:0]       held_nxt [HoldMax];
  logic [7:0]       close_r, close_nxt;    // closing byte kept for failure path
  // output list: '&', held bytes, trailing byte; or decoded bytes
  logic [7:0]       ob_r [4];
  logic [7:0]       ob_nxt [4];
  logic             ofl_r, ofl_nxt;        // flush mode: list from held bytes
  logic             otail_r, otail_nxt;    // flush ends with close_r
  logic [OcW-1:0]   ocnt_r, ocnt_nxt;      // bytes left
  logic [OcW-1:0]   opos_r, opos_nxt;      // position in flush list
  logic             dec_r, dec_nxt;        // a decode is pending
  logic             num_r, num_nxt;
  // number parser
  logic [HcW-1:0]   pp_r, pp_nxt;
  phase_t           ph_r, ph_nxt;
  logic             hex_r, hex_nxt;
  logic             neg_r, neg_nxt;
  logic             pdone_r, pdone_nxt;
  logic [31:0]      val_r, val_nxt;
  // name matcher
  logic [3:0]       ek_r, ek_nxt;
  logic             ehit_r, ehit_nxt;
  logic [3:0]       ehk_r, ehk_nxt;

  logic [7:0] b;
  logic       gap;
  logic [7:0] cur, nx1, nx2;
  logic [4:0] dv;
  logic [4:0] dv2;
  logic [31:0] nval, fval;
  entity_t    e;
  entity_t    hit_e;
  logic       same;
  logic       fail;
  logic [2:0] dn;

  assign b = in_byte;
  assign gap = b == 8'h20 || b == 8'h09 || b == 8'h0A || b == 8'h0D || b == 8'h0C;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inref_r <= 1'b0;
      hcnt_r  <= '0;
      ocnt_r  <= '0;
      dec_r   <= 1'b0;
      pdone_r <= 1'b0;
    end else begin
      inref_r <= inref_nxt;
      hcnt_r  <= hcnt_nxt;
      ocnt_r  <= ocnt_nxt;
      dec_r   <= dec_nxt;
      pdone_r <= pdone_nxt;
    end
  end

  always_ff @(posedge clk) begin
    held_r  <= held_nxt;
    close_r <= close_nxt;
    ob_r    <= ob_nxt;
    ofl_r   <= ofl_nxt;
    otail_r <= otail_nxt;
    opos_r  <= opos_nxt;
    num_r   <= num_nxt;
    pp_r    <= pp_nxt;
    ph_r    <= ph_nxt;
    hex_r   <= hex_nxt;
    neg_r   <= neg_nxt;
    val_r   <= val_nxt;
    ek_r    <= ek_nxt;
    ehit_r  <= ehit_nxt;
    ehk_r   <= ehk_nxt;
  end

  // held byte reads at parse pointer (small register file, mux reads)
  always_comb begin
    cur = held_r[pp_r[HiW-1:0]];
    nx1 = (pp_r + 1 < HcW'(HoldMax)) ? held_r[HiW'(pp_r + 1)] : 8'h00;
    nx2 = (pp_r + 2 < HcW'(HoldMax)) ? held_r[HiW'(pp_r + 2)] : 8'h00;
  end

  assign dv = digit_val(cur, hex_r);
  assign dv2 = digit_val(nx2, 1'b1);
  assign nval = hex_r ? {val_r[27:0], 4'h0} + 32'(dv[3:0])
                      : {val_r[28:0], 3'h0} + {val_r[30:0], 1'b0} + 32'(dv[3:0]);
  assign fval = neg_r ? (32'h0 - val_r) : val_r;

  always_comb begin
    e = ent(ek_r);
    same = 32'(e.len) == 32'(hcnt_r);
    for (int i = 0; i < 6; i++)
      if (i < int'(e.len) && fold(held_r[i]) != e.name[i]) same = 1'b0;
  end

  always_comb begin
    inref_nxt = inref_r; hcnt_nxt = hcnt_r; held_nxt = held_r; close_nxt = close_r;
    ob_nxt = ob_r; ofl_nxt = ofl_r; otail_nxt = otail_r; ocnt_nxt = ocnt_r;
    opos_nxt = opos_r; dec_nxt = dec_r; num_nxt = num_r; pp_nxt = pp_r;
    ph_nxt = ph_r; hex_nxt = hex_r; neg_nxt = neg_r; pdone_nxt = pdone_r;
    val_nxt = val_r; ek_nxt = ek_r; ehit_nxt = ehit_r; ehk_nxt = ehk_r;
    fail = 1'b0; dn = '0;
    hit_e = ent(ehit_r ? ehk_r : ek_r);

    if (cmd.take) begin
      dec_nxt = 1'b0;
      ofl_nxt = 1'b0;
      ocnt_nxt = '0;
      opos_nxt = '0;
      close_nxt = b;
      otail_nxt = 1'b0;
      if (!inref_r) begin
        if (b == ChAmp && !in_end) begin
          inref_nxt = 1'b1; hcnt_nxt = '0;
        end else begin
          ob_nxt[0] = b; ocnt_nxt = OcW'(1);
        end
      end else if (b == ChSemi) begin
        inref_nxt = 1'b0;
        if (hcnt_r == '0) begin
          ofl_nxt = 1'b1; otail_nxt = 1'b1; ocnt_nxt = OcW'(2);
        end else begin
          dec_nxt = 1'b1;
          num_nxt = held_r[0] == "#";
        end
      end else if (gap) begin
        inref_nxt = 1'b0;
        ofl_nxt = 1'b1; otail_nxt = 1'b1;
        ocnt_nxt = OcW'(hcnt_r) + OcW'(2);
        hcnt_nxt = '0;
      end else if (b == ChAmp) begin
        ofl_nxt = 1'b1; otail_nxt = in_end;
        ocnt_nxt = OcW'(hcnt_r) + OcW'(in_end ? 2 : 1);
        hcnt_nxt = '0;
      end else begin
        held_nxt[hcnt_r[HiW-1:0]] = b;
        if (hcnt_r + 1 >= HcW'(HoldMax) || in_end) begin
          inref_nxt = 1'b0;
          ofl_nxt = 1'b1;
          ocnt_nxt = OcW'(hcnt_r) + OcW'(2);
          hcnt_nxt = '0;
        end else begin
          hcnt_nxt = hcnt_r + 1'b1;
        end
      end
      if (in_end) inref_nxt = 1'b0;
      // a decode keeps hcnt until finish; otherwise end clears it
      if (in_end && !(inref_r && b == ChSemi && hcnt_r != '0)) hcnt_nxt = '0;
    end

    if (cmd.parse_init) begin
      // "#x" with more after it is hex, otherwise decimal from byte 1
      hex_nxt = hcnt_r > HcW'(2) && (held_r[1] | 8'h20) == "x";
      pp_nxt = (hcnt_r > HcW'(2) && (held_r[1] | 8'h20) == "x") ? HcW'(2) : HcW'(1);
      ph_nxt = PH_WS; neg_nxt = 1'b0; val_nxt = '0; pdone_nxt = 1'b0;
      ek_nxt = '0; ehit_nxt = 1'b0; ehk_nxt = '0;
    end

    if (cmd.parse_step && !pdone_r) begin
      if (pp_r >= hcnt_r) pdone_nxt = 1'b1;
      else begin
        case (ph_r)
          PH_WS: if (cur == ChVt) pp_nxt = pp_r + 1'b1; else ph_nxt = PH_SIGN;
          PH_SIGN: begin
            ph_nxt = PH_PFX;
            if (cur == "+" || cur == "-") begin
              neg_nxt = cur == "-"; pp_nxt = pp_r + 1'b1;
            end
          end
          PH_PFX: begin
            ph_nxt = PH_DIG;
            if (hex_r && pp_r + 2 < hcnt_r && cur == "0" && (nx1 | 8'h20) == "x"
                && !dv2[4])
              pp_nxt = pp_r + 2'd2;
          end
          PH_DIG: begin
            if (dv[4]) pdone_nxt = 1'b1;
            else begin val_nxt = nval; pp_nxt = pp_r + 1'b1; end
          end
          default: pdone_nxt = 1'b1;
        endcase
      end
    end

    if (cmd.name_step && !ehit_r) begin
      if (same) begin ehit_nxt = 1'b1; ehk_nxt = ek_r; end
      ek_nxt = ek_r + 1'b1;
    end

    if (cmd.finish) begin
      dec_nxt = 1'b0;
      if (num_r) begin
        if (fval == '0) fail = 1'b1;
        else if (fval > 32'h10FFFF) dn = '0;
        else if (fval <= 32'h7F) begin
          ob_nxt[0] = fval[7:0]; dn = 3'd1;
        end else if (fval <= 32'h7FF) begin
          ob_nxt[0] = 8'hC0 | 8'(fval[10:6]); ob_nxt[1] = 8'h80 | 8'(fval[5:0]);
          dn = 3'd2;
        end else if (fval <= 32'hFFFF) begin
          ob_nxt[0] = 8'hE0 | 8'(fval[15:12]);
          ob_nxt[1] = 8'h80 | 8'(fval[11:6]);
          ob_nxt[2] = 8'h80 | 8'(fval[5:0]); dn = 3'd3;
        end else begin
          ob_nxt[0] = 8'hF0 | 8'(fval[20:18]);
          ob_nxt[1] = 8'h80 | 8'(fval[17:12]);
          ob_nxt[2] = 8'h80 | 8'(fval[11:6]);
          ob_nxt[3] = 8'h80 | 8'(fval[5:0]); dn = 3'd4;
        end
      end else if (ehit_r || same) begin
        ob_nxt[0] = hit_e.text0; ob_nxt[1] = hit_e.text1;
        dn = hit_e.two ? 3'd2 : 3'd1;
      end else fail = 1'b1;
      if (fail) begin
        ofl_nxt = 1'b1; otail_nxt = 1'b1;
        ocnt_nxt = OcW'(hcnt_r) + OcW'(2);
      end else begin
        ofl_nxt = 1'b0; ocnt_nxt = OcW'(dn);
      end
      hcnt_nxt = '0;
    end

    if (cmd.emit_pop) begin
      ocnt_nxt = ocnt_r - 1'b1;
      opos_nxt = opos_r + 1'b1;
    end
  end

  // emitted byte
  always_comb begin
    out_byte = ob_r[opos_r[1:0]];
    if (ofl_r) begin
      if (opos_r == '0) out_byte = ChAmp;
      else if (otail_r && ocnt_r == OcW'(1)) out_byte = close_r;
      else out_byte = held_r[HiW'(opos_r - 1'b1)];
    end
  end
  assign out_run_last = ocnt_r == OcW'(1);

  assign st.need_decode = dec_nxt && cmd.take;
  assign st.numeric     = num_nxt;
  assign st.parse_done  = pdone_r;
  assign st.name_done   = ehit_r || same || ek_r == 4'd15;
  assign st.emit_any    = ocnt_nxt != '0;
  assign st.emit_last   = ocnt_r == OcW'(1);
endmodule

[sv/html_entity_decoder.sv]
`timescale 1ns / 1ps
// HTML character reference decoder. Text bytes enter one per transfer with an
// end-of-text mark; decoded bytes leave one per transfer, the last byte caused
// by an input flagged on out_run_last. An input byte is taken while the
// decoder is idle; its result bytes then leave one a cycle unless out_stall
// holds them, and the next byte is taken after the last result transfer. A
// ';' that closes a numeric reference first runs the digit walker: it steps
// over the held bytes and its phase steps, sees the end of the digits and
// builds the result. A named reference first runs the name matcher, which
// tries one entity a cycle. A code point above range writes nothing and the
// input reopens straight after the walk. Failed references replay '&', the
// held bytes and the closing byte.
module html_entity_decoder (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_end,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_run_last
);
  import hed_pkg::*;

  cmd_t  cmd;   // controller commands
  stat_t st;    // datapath status

  hed_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall, .cmd, .st
  );

  hed_dp u_dp (
    .clk, .rst_n, .in_byte, .in_end, .out_byte, .out_run_last, .cmd, .st
  );
endmodule

[sv/hed_checker.sv]
`timescale 1ns / 1ps
`include "html_entity_decoder_macros.svh"
module hed_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_byte,
  input logic       out_run_last
);
  // one side at a time: a result never shows while input is open
  `HED_ASSERT(a_excl, out_valid, in_stall)
  // held result keeps its byte
  `HED_ASSERT_NEXT(a_hold, out_valid && out_stall, $stable(out_byte))
  // after the last result transfer the input opens again
  `HED_ASSERT_NEXT(a_reopen, out_valid && !out_stall && out_run_last, !in_stall)
endmodule

bind html_entity_decoder hed_checker u_hed_checker (.*);
